// ===== src/plsb_pkg.sv =====
package plsb_pkg;

  localparam int MSG_DEPTH_DEF = 1024;
  localparam int MAX_DIM_DEF   = 4096;
  localparam int CFG_W         = 13;
  localparam int DIM_RESET     = 8;
  localparam int DIM_MIN       = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CAPACITY = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    status_t    status;
    logic       sig;
    chan_t      sig_ch;
    logic       sig_mark;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
    status_t    status;
  } pix_out_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } msg_wr_t;

endpackage

// ===== src/plsb_queue.sv =====
module plsb_queue
  import plsb_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/plsb_front.sv =====
module plsb_front
  import plsb_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF,
  localparam int LEN_W    = $clog2(MSG_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [7:0]                    message_byte,
  input  logic                          message_last,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  input  logic                          config_write,
  input  logic                          config_index,
  input  logic [CFG_W-1:0]              config_data,
  output logic                          q_push,
  output logic [$bits(pix_t)+LEN_W-1:0] q_data,
  input  logic                          q_full,
  input  logic                          frame_done,
  output msg_wr_t                       msg_wr,
  output logic [LEN_W-1:0]              fill
);

  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int CAP_W       = 2 * DIM_W + 2;
  localparam int CMP_W       = (LEN_W > CAP_W) ? LEN_W : CAP_W;
  localparam int END_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SIG_SPAN    = 4;
  localparam int CAP_RESERVE = 12;
  localparam logic [CAP_W-1:0] CAP_RESET =
    CAP_W'(DIM_RESET * DIM_RESET * 3 / 4 - CAP_RESERVE);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(MSG_DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'(DIM_MIN)) begin
      w = 32'(DIM_MIN);
    end else if (w > 32'(MAX_DIM)) begin
      w = 32'(MAX_DIM);
    end
    return DIM_W'(w);
  endfunction

  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [DIM_W-1:0]   rows_next;
  logic [DIM_W-1:0]   cols_next;
  logic [CAP_W-1:0]   cap;
  logic [CAP_W-1:0]   cap_next;
  logic [2*DIM_W-1:0] area;

  logic [LEN_W-1:0] length;
  logic             overflow;
  logic             closed;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic [END_W-1:0] ends_pending;

  logic             accept;
  logic             byte_acc;
  logic             pix_acc;
  logic [DIM_W-1:0] r_ext;
  logic [DIM_W-1:0] c_ext;
  logic [DIM_W-1:0] n1;
  logic [DIM_W-1:0] m1;
  logic [DIM_W-1:0] green_k;
  logic [DIM_W-1:0] blue_k;
  logic             col_wrap;
  logic             row_wrap;
  logic             is_last;
  logic             red_hit;
  logic             green_hit;
  logic             blue_hit;
  pix_t             pix;

  // capacity is refreshed on the same edge as the dimensions
  always_comb begin
    rows_next = rows;
    cols_next = cols;
    if (config_write) begin
      if (config_index == REG_ROWS) begin
        rows_next = clamp_dim(config_data);
      end else begin
        cols_next = clamp_dim(config_data);
      end
    end
    area     = (2*DIM_W)'(rows_next) * (2*DIM_W)'(cols_next);
    cap_next = CAP_W'((CAP_W'(area) * CAP_W'(3)) >> 2) - CAP_W'(CAP_RESERVE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= DIM_W'(DIM_RESET);
      cols <= DIM_W'(DIM_RESET);
      cap  <= CAP_RESET;
    end else begin
      rows <= rows_next;
      cols <= cols_next;
      cap  <= cap_next;
    end
  end

  assign in_stall = (operation == OP_PIXEL) ? q_full : (ends_pending != '0);
  assign accept   = in_valid && !in_stall;
  assign byte_acc = accept && (operation == OP_BYTE);
  assign pix_acc  = accept && (operation == OP_PIXEL);

  always_comb begin
    r_ext     = DIM_W'(row);
    c_ext     = DIM_W'(col);
    n1        = rows - 1'b1;
    m1        = cols - 1'b1;
    green_k   = m1 - c_ext;
    blue_k    = n1 - r_ext;
    col_wrap  = (c_ext >= m1);
    row_wrap  = (r_ext >= n1);
    is_last   = col_wrap && row_wrap;
    red_hit   = (r_ext < DIM_W'(SIG_SPAN)) && (c_ext == m1);
    green_hit = (r_ext == n1) && (c_ext <= m1) && (green_k < DIM_W'(SIG_SPAN));
    blue_hit  = (c_ext == '0) && (r_ext <= n1) && (blue_k < DIM_W'(SIG_SPAN));

    pix          = '0;
    pix.red      = red_in;
    pix.green    = green_in;
    pix.blue     = blue_in;
    pix.last     = is_last;
    pix.sig_ch   = CH_RED;
    if (overflow) begin
      pix.status = STATUS_OVERFLOW;
    end else if (CMP_W'(length) > CMP_W'(cap)) begin
      pix.status = STATUS_CAPACITY;
    end else begin
      pix.status = STATUS_OK;
    end
    if (red_hit) begin
      pix.sig      = 1'b1;
      pix.sig_ch   = CH_RED;
      pix.sig_mark = !r_ext[0];
    end else if (green_hit) begin
      pix.sig      = 1'b1;
      pix.sig_ch   = CH_GREEN;
      pix.sig_mark = !green_k[0];
    end else if (blue_hit) begin
      pix.sig      = 1'b1;
      pix.sig_ch   = CH_BLUE;
      pix.sig_mark = !blue_k[0];
    end
  end

  assign q_push      = pix_acc;
  assign q_data      = {pix, length};
  assign msg_wr.en   = byte_acc && !closed && (length < DEPTH_LEN);
  assign msg_wr.data = message_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      length       <= '0;
      fill         <= '0;
      overflow     <= 1'b0;
      closed       <= 1'b0;
      row          <= '0;
      col          <= '0;
      ends_pending <= '0;
    end else begin
      if (byte_acc && !closed) begin
        if (msg_wr.en) begin
          length <= length + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
        if (message_last) begin
          closed <= 1'b1;
        end
      end

      if (frame_done) begin
        fill <= '0;
      end else if (msg_wr.en) begin
        fill <= fill + 1'b1;
      end

      if (pix_acc) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        if (is_last) begin
          length   <= '0;
          overflow <= 1'b0;
          closed   <= 1'b0;
        end
      end

      if (pix_acc && is_last && !frame_done) begin
        ends_pending <= ends_pending + 1'b1;
      end else if (!(pix_acc && is_last) && frame_done) begin
        ends_pending <= ends_pending - 1'b1;
      end
    end
  end

  a_write_at_fill: assert property (@(posedge clk) disable iff (rst)
    msg_wr.en |-> (fill == length))
    else $error("message write while store fill and length disagree");

  a_ends_bound: assert property (@(posedge clk) disable iff (rst)
    ends_pending <= END_W'(QUEUE_DEPTH))
    else $error("more frame ends in flight than queue slots");

endmodule

// ===== src/plsb_back.sv =====
module plsb_back
  import plsb_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  localparam int LEN_W    = $clog2(MSG_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  logic [$bits(pix_t)+LEN_W-1:0] head_data,
  output logic                          pop,
  input  msg_wr_t                       msg_wr,
  input  logic [LEN_W-1:0]              fill,
  output logic                          frame_done,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pix_out_t                      out_pix
);

  localparam int ADDR_W     = $clog2(MSG_DEPTH);
  localparam int WIN_DEPTH  = 4;
  localparam int WCNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int WIDX_W     = $clog2(WIN_DEPTH);
  localparam int TERM_PAIRS = 4;
  localparam int TERM_W     = $clog2(TERM_PAIRS + 1);

  function automatic logic [1:0] pair_sel(input logic [7:0] b, input logic [1:0] p);
    logic [1:0] r;
    unique case (p)
      2'd3:    r = b[7:6];
      2'd2:    r = b[5:4];
      2'd1:    r = b[3:2];
      default: r = b[1:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] put_low2(input logic [7:0] s, input logic [1:0] bits);
    return {s[7:2], bits};
  endfunction

  logic [7:0]        store [MSG_DEPTH];
  logic [LEN_W-1:0]  fetch_idx;
  logic              rd_pend;
  logic [7:0]        rd_data;
  logic [7:0]        win [WIN_DEPTH];
  logic [7:0]        win_next [WIN_DEPTH];
  logic [WCNT_W-1:0] win_cnt;
  logic [WCNT_W-1:0] occ;
  logic [WCNT_W-1:0] base;
  logic              issue;
  logic              win_pop;

  logic [LEN_W-1:0]  ri;
  logic [1:0]        pair_pos;
  logic [TERM_W-1:0] term_cnt;
  logic              finished;

  pix_t              pix;
  logic [LEN_W-1:0]  pix_len;
  logic [7:0]        ch [3];
  logic [7:0]        cur;
  logic [1:0]        mark;
  logic [1:0]        need;
  logic              adv;
  logic [LEN_W-1:0]  ri_v;
  logic [1:0]        p_v;
  logic [TERM_W-1:0] tc_v;
  logic              fin_v;
  logic              out_free;
  logic              go;

  assign {pix, pix_len} = head_data;

  always_ff @(posedge clk) begin
    if (msg_wr.en) begin
      store[fill[ADDR_W-1:0]] <= msg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= store[fetch_idx[ADDR_W-1:0]];
    end
  end

  assign occ   = win_cnt + WCNT_W'(rd_pend);
  assign issue = (fetch_idx < fill) && (occ < WCNT_W'(WIN_DEPTH));

  // win[0] holds the byte at ri, win[1] the one after it
  always_comb begin
    ch[0] = pix.red;
    ch[1] = pix.green;
    ch[2] = pix.blue;
    cur   = win[0];
    mark  = 2'b00;
    need  = 2'd0;
    adv   = 1'b0;
    ri_v  = ri;
    p_v   = pair_pos;
    tc_v  = term_cnt;
    fin_v = finished;
    if (pix.status == STATUS_OK) begin
      if (pix.sig) begin
        mark = pix.sig_mark ? 2'b11 : 2'b00;
        unique case (pix.sig_ch)
          CH_RED:   ch[0] = put_low2(ch[0], mark);
          CH_GREEN: ch[1] = put_low2(ch[1], mark);
          CH_BLUE:  ch[2] = put_low2(ch[2], mark);
          default:  ch[0] = pix.red;
        endcase
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (!fin_v) begin
            if (ri_v < pix_len) begin
              cur   = adv ? win[1] : win[0];
              need  = adv ? 2'd2 : 2'd1;
              ch[k] = put_low2(ch[k], pair_sel(cur, p_v));
              if (p_v == 2'd0) begin
                p_v  = 2'd3;
                ri_v = ri_v + 1'b1;
                adv  = 1'b1;
              end else begin
                p_v = p_v - 2'd1;
              end
            end else begin
              ch[k] = put_low2(ch[k], 2'b00);
              tc_v  = tc_v + 1'b1;
              if (tc_v >= TERM_W'(TERM_PAIRS)) begin
                fin_v = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign out_free   = !out_valid || !out_stall;
  assign go         = head_valid && out_free && (win_cnt >= WCNT_W'(need));
  assign pop        = go;
  assign frame_done = go && pix.last;
  assign win_pop    = go && adv;
  assign base       = win_cnt - WCNT_W'(win_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_pix <= '{red: ch[0], green: ch[1], blue: ch[2],
                   frame_end: pix.last, status: pix.status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ri       <= '0;
      pair_pos <= 2'd3;
      term_cnt <= '0;
      finished <= 1'b0;
    end else if (go) begin
      if (pix.last) begin
        ri       <= '0;
        pair_pos <= 2'd3;
        term_cnt <= '0;
        finished <= 1'b0;
      end else begin
        ri       <= ri_v;
        pair_pos <= p_v;
        term_cnt <= tc_v;
        finished <= fin_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_idx <= '0;
      rd_pend   <= 1'b0;
      win_cnt   <= '0;
    end else if (frame_done) begin
      fetch_idx <= '0;
      rd_pend   <= 1'b0;
      win_cnt   <= '0;
    end else begin
      if (issue) begin
        fetch_idx <= fetch_idx + 1'b1;
      end
      rd_pend <= issue;
      win_cnt <= base + WCNT_W'(rd_pend);
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_next[i] = win[i];
    end
    if (win_pop) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_next[i] = win[i+1];
      end
    end
    if (rd_pend) begin
      win_next[base[WIDX_W-1:0]] = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= WCNT_W'(WIN_DEPTH))
    else $error("byte window overfilled");

  a_flush: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> (win_cnt == '0 && !rd_pend && ri == '0 && fetch_idx == '0))
    else $error("embedding state not cleared after frame end");

  a_pop_has_byte: assert property (@(posedge clk) disable iff (rst)
    win_pop |-> (win_cnt != '0))
    else $error("byte consumed from empty window");

endmodule

// ===== src/pixel_lsb_text_embedder.sv =====
// Hides a text in the two low bits of each sample of an RGB image.
// Input channel (in_valid/in_stall): operation 0 carries a message byte,
// operation 1 a pixel in raster order. Load the message bytes first; bytes
// sent during an image are appended. Output channel (out_valid/out_stall):
// one transaction per pixel, none per message byte, frame_end on the last
// pixel of the image and status 0 ok, 1 too long for the image, 2 overflow.
// Configuration: config_write/config_index/config_data write image_rows (0)
// and image_cols (1); write only while the block is idle.
// Throughput: one pixel per cycle unless the output stalls or a pixel waits
// at the queue head for a byte still being read from the message store (one
// read port, one byte per cycle while the four-byte prefetch window has
// room). Accepted pixels pass the queue, then the output register. Message
// bytes are taken one per cycle, but are held off while the last pixel of an
// image is still queued. A four-entry queue separates classification from
// embedding; when the receiver stalls, the output register holds and the
// queue fills, then pixels are stalled. Reset sets both dimensions to 8 and
// empties the message; the store contents are not cleared.
module pixel_lsb_text_embedder
  import plsb_pkg::*;
#(
  parameter int MSG_DEPTH = MSG_DEPTH_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [7:0]       message_byte,
  input  logic             message_last,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic             frame_end,
  output logic [1:0]       status,
  input  logic             config_write,
  input  logic             config_index,
  input  logic [CFG_W-1:0] config_data
);

  localparam int LEN_W = $clog2(MSG_DEPTH + 1);
  localparam int Q_W   = $bits(pix_t) + LEN_W;

  logic             q_push;
  logic [Q_W-1:0]   q_data;
  logic             q_full;
  logic             q_pop;
  logic             head_valid;
  logic [Q_W-1:0]   head_data;
  logic             frame_done;
  msg_wr_t          msg_wr;
  logic [LEN_W-1:0] fill;
  pix_out_t         out_pix;

  plsb_front #(
    .MSG_DEPTH (MSG_DEPTH),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .message_byte (message_byte),
    .message_last (message_last),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .q_push       (q_push),
    .q_data       (q_data),
    .q_full       (q_full),
    .frame_done   (frame_done),
    .msg_wr       (msg_wr),
    .fill         (fill)
  );

  plsb_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  plsb_back #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (q_pop),
    .msg_wr     (msg_wr),
    .fill       (fill),
    .frame_done (frame_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pix    (out_pix)
  );

  assign red_out   = out_pix.red;
  assign green_out = out_pix.green;
  assign blue_out  = out_pix.blue;
  assign frame_end = out_pix.frame_end;
  assign status    = out_pix.status;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import plsb_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_TARGET = 300;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             operation;
  logic [7:0]       message_byte;
  logic             message_last;
  logic [7:0]       red_in;
  logic [7:0]       green_in;
  logic [7:0]       blue_in;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       red_out;
  logic [7:0]       green_out;
  logic [7:0]       blue_out;
  logic             frame_end;
  logic [1:0]       status;
  logic             config_write;
  logic             config_index;
  logic [CFG_W-1:0] config_data;

  pixel_lsb_text_embedder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .message_byte (message_byte),
    .message_last (message_last),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .frame_end    (frame_end),
    .status       (status),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data)
  );

  // embedder state mirror
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [7:0]       text_buf [MSG_DEPTH_DEF];
  logic [10:0]      text_len;
  logic [10:0]      next_byte;
  logic [1:0]       pair_sel;
  logic [2:0]       zero_pairs;
  logic             text_done;
  logic [11:0]      pix_row;
  logic [11:0]      pix_col;
  logic             buf_over;
  logic             text_sealed;
  logic             image_done;

  pix_out_t    pending_pixels [$];
  int unsigned errors;
  int unsigned items_done;
  int unsigned idle_cycles;
  logic        quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned dim_of(input logic [CFG_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  function automatic longint unsigned room_for(input int unsigned n, input int unsigned m);
    return (longint'(n) * m * 6) / 8 - 12;
  endfunction

  function automatic int unsigned mark_slot(input int unsigned r, input int unsigned c,
                                            input int unsigned n, input int unsigned m);
    for (int unsigned k = 0; k < 4; k++) begin
      if (r == k && c == m - 1) return k;
      if (r == n - 1 && c == m - 1 - k) return 4 + k;
      if (r == n - 1 - k && c == 0) return 8 + k;
    end
    return 12;
  endfunction

  function automatic void clear_progress();
    next_byte  = '0;
    pair_sel   = 2'd3;
    zero_pairs = '0;
    text_done  = 1'b0;
    pix_row    = '0;
    pix_col    = '0;
  endfunction

  function automatic void mirror_reset();
    rows_reg    = CFG_W'(DIM_RESET);
    cols_reg    = CFG_W'(DIM_RESET);
    text_len    = '0;
    buf_over    = 1'b0;
    text_sealed = 1'b0;
    clear_progress();
  endfunction

  // returns 1 when the byte is not ignored
  function automatic bit load_byte(input logic [7:0] v, input logic last_v);
    if (text_sealed) return 1'b0;
    if (text_len >= MSG_DEPTH_DEF) begin
      buf_over = 1'b1;
    end else begin
      text_buf[text_len] = v;
      text_len++;
    end
    if (last_v) text_sealed = 1'b1;
    return 1'b1;
  endfunction

  function automatic pix_out_t embed_pixel(input logic [7:0] r, g, b);
    int unsigned    n;
    int unsigned    m;
    int unsigned    slot;
    longint unsigned room;
    logic [7:0]     smp [3];
    logic [7:0]     src;
    status_t        st;
    logic           ends;
    pix_out_t       res;
    n = dim_of(rows_reg);
    m = dim_of(cols_reg);
    smp[0] = r;
    smp[1] = g;
    smp[2] = b;
    room = room_for(n, m);
    if (buf_over) st = STATUS_OVERFLOW;
    else if (text_len > room) st = STATUS_CAPACITY;
    else st = STATUS_OK;
    if (st == STATUS_OK) begin
      slot = mark_slot(pix_row, pix_col, n, m);
      if (slot < 12) begin
        smp[slot / 4][1:0] = (slot % 2 == 0) ? 2'b11 : 2'b00;
      end else begin
        for (int k = 0; k < 3 && !text_done; k++) begin
          if (next_byte < text_len && next_byte < MSG_DEPTH_DEF) begin
            src = text_buf[next_byte];
            smp[k][1:0] = src[{pair_sel, 1'b0} +: 2];
            if (pair_sel == 2'd0) begin
              pair_sel = 2'd3;
              next_byte++;
            end else begin
              pair_sel--;
            end
          end else begin
            smp[k][1:0] = 2'b00;
            zero_pairs++;
            if (zero_pairs >= 4) text_done = 1'b1;
          end
        end
      end
    end
    ends = 1'b0;
    if (pix_col >= m - 1) begin
      pix_col = '0;
      if (pix_row >= n - 1) ends = 1'b1;
      else pix_row++;
    end else begin
      pix_col++;
    end
    res.red       = smp[0];
    res.green     = smp[1];
    res.blue      = smp[2];
    res.frame_end = ends;
    res.status    = st;
    if (ends) begin
      clear_progress();
      text_len    = '0;
      buf_over    = 1'b0;
      text_sealed = 1'b0;
      image_done  = 1'b1;
    end
    return res;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = pause_len();
      end
    end
  end

  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: r=%h g=%h b=%h end=%b st=%0d",
                   red_out, green_out, blue_out, frame_end, status);
      end else begin
        want = pending_pixels.pop_front();
        if (red_out !== want.red || green_out !== want.green || blue_out !== want.blue ||
            frame_end !== want.frame_end || status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp r=%h g=%h b=%h end=%b st=%0d, ",
                      "got r=%h g=%h b=%h end=%b st=%0d"},
                     want.red, want.green, want.blue, want.frame_end, want.status,
                     red_out, green_out, blue_out, frame_end, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic op, input logic [7:0] v, input logic last_v,
                           input logic [7:0] r, g, b);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 99) < 25) ? pause_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    operation    <= op;
    message_byte <= v;
    message_last <= last_v;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_PIXEL) begin
      pending_pixels.push_back(embed_pixel(r, g, b));
      items_done++;
    end else if (load_byte(v, last_v)) begin
      items_done++;
    end
  endtask

  task automatic send_text_byte(input logic [7:0] v, input logic last_v);
    send_item(OP_BYTE, v, last_v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic random_pixel();
    send_item(OP_PIXEL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic load_text(input int unsigned len, input bit seal);
    logic [7:0] v;
    for (int unsigned i = 0; i < len; i++) begin
      v = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_text_byte(v, seal && i == len - 1);
    end
  endtask

  task automatic finish_image(input bit extreme, input bit stray);
    logic [7:0] v;
    bit         flip;
    flip = 1'b0;
    image_done = 1'b0;
    while (!image_done) begin
      if (stray && $urandom_range(0, 29) == 0)
        send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      if (extreme) begin
        v = flip ? 8'hFF : 8'h00;
        send_item(OP_PIXEL, ~v, ~flip, v, v, v);
        flip = !flip;
      end else begin
        random_pixel();
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    wait_drained();
    @(negedge clk);
    config_write <= 1'b1;
    config_index <= idx;
    config_data  <= data;
    if (idx == REG_ROWS) rows_reg = data;
    else cols_reg = data;
    @(negedge clk);
    config_write <= 1'b0;
  endtask

  task automatic test_signature_embed();
    quiet = 1'b1;
    write_reg(REG_ROWS, 13'd8);
    write_reg(REG_COLS, 13'd8);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'hA5, 1'b0);
    send_text_byte(8'h5A, 1'b1);
    send_text_byte(8'h81, 1'b0);  // closed message, dropped
    finish_image(1'b1, 1'b0);
  endtask

  task automatic test_mid_image_bytes();
    quiet = 1'b0;
    load_text(3, 1'b0);
    repeat (10) random_pixel();
    send_text_byte(8'h3C, 1'b0);
    send_text_byte(8'hC3, 1'b1);
    send_text_byte(8'h7E, 1'b0);
    finish_image(1'b0, 1'b0);
  endtask

  task automatic test_capacity();
    quiet = 1'($urandom_range(0, 1));
    load_text(37, 1'b1);
    finish_image(1'b0, 1'b0);
    load_text(36, 1'b1);
    finish_image(1'b0, 1'b0);
  endtask

  task automatic test_overflow();
    quiet = 1'b0;
    load_text(1026, 1'b1);
    finish_image(1'b0, 1'b0);
  endtask

  task automatic test_dimension_limits();
    quiet = 1'b0;
    write_reg(REG_ROWS, 13'd4096);
    write_reg(REG_COLS, 13'd4096);
    load_text(6, 1'b1);
    repeat (5) random_pixel();
    write_reg(REG_ROWS, 13'd0);
    write_reg(REG_COLS, 13'h1FFF);
    repeat (15) random_pixel();
    write_reg(REG_COLS, 13'd8);  // column already past the edge
    finish_image(1'b0, 1'b0);
    write_reg(REG_ROWS, 13'h1FFF);
    write_reg(REG_COLS, 13'd7);
    load_text(8, 1'b1);
    repeat (80) random_pixel();
    write_reg(REG_ROWS, 13'd8);  // row already past the edge
    finish_image(1'b0, 1'b0);
  endtask

  task automatic test_random_images();
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] cv;
    int unsigned      room;
    int unsigned      pick;
    items_done = 0;
    while (items_done < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      rv = CFG_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 14));
      cv = CFG_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 14));
      write_reg(REG_ROWS, rv);
      write_reg(REG_COLS, cv);
      room = 32'(room_for(dim_of(rv), dim_of(cv)));
      pick = $urandom_range(0, 99);
      if (pick < 10) load_text(room, 1'b1);
      else if (pick < 70) load_text($urandom_range(0, room), 1'b1);
      else if (pick < 85) load_text($urandom_range(room + 1, room + 4), 1'b1);
      else load_text($urandom_range(0, room), 1'b0);
      if ($urandom_range(0, 3) == 0) load_text($urandom_range(1, 3), 1'b1);
      finish_image(1'b0, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_BYTE;
    message_byte = '0;
    message_last = 1'b0;
    red_in       = '0;
    green_in     = '0;
    blue_in      = '0;
    config_write = 1'b0;
    config_index = REG_ROWS;
    config_data  = '0;
    errors       = 0;
    items_done   = 0;
    quiet        = 1'b1;
    image_done   = 1'b0;
    mirror_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_signature_embed();
    test_mid_image_bytes();
    test_capacity();
    test_overflow();
    test_dimension_limits();
    test_random_images();

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("missing %0d output transactions", pending_pixels.size());
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
